/* rtl/masked_byte_pattern_search_unit_defines.svh */
// Assertion macros for the checker file of the pattern search unit
`ifndef MASKED_BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_UNIT_DEFINES_SVH

// property checked on every rising edge outside reset
`define MBPS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mbps assertion failed");

// property checked on every rising edge, reset included
`define MBPS_ASSERT_ALL(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mbps assertion failed");

`endif

/* rtl/mbps_pkg.sv */
// Shared types and constants of the masked byte pattern search unit
package mbps_pkg;

   localparam int PAT_BYTES = 16;  // pattern register bytes
   localparam int LEN_W     = 5;   // pattern_length register width
   localparam int OFFSET_W  = 32;  // byte count and match offset width

   typedef enum logic [1:0] {
      CSR_PAT_LO = 2'd0,
      CSR_PAT_HI = 2'd1,
      CSR_CARE   = 2'd2,
      CSR_LEN    = 2'd3
   } csr_index_type;

   // pattern setup broadcast to every window cell
   typedef struct packed {
      logic [PAT_BYTES-1:0][7:0] pat;
      logic [PAT_BYTES-1:0]      care;
      logic [LEN_W-1:0]          len;   // effective length, 1 or more
   } cell_cfg_type;

endpackage

/* rtl/masked_byte_pattern_search_unit.sv */
// Top level: a chain of window cells with byte counter, search control and result register.
// Takes one buffer byte per clock with no gaps and reports the first offset at which the newest
// pattern_length bytes match the pattern on every position whose care bit is set; a buffer that
// ends without a match reports found = 0, offset 0. The result word appears in the cycle after
// the byte that decides it, whose cycle holds each cell's byte compare, the chain AND and the
// 32-bit count compare. A pending result does not stop the input while rsp_tready takes it.
// The user writes configuration only while no buffer is in flight; the block does not check it.
module masked_byte_pattern_search_unit #(
   parameter int MAX_PATTERN = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] match_offset
   output logic        rsp_tuser,   // [0] found
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import mbps_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN =
      (MAX_PATTERN > 31) ? 5'd31 : LEN_W'(MAX_PATTERN);

   logic [63:0]         pat_lo_ff;
   logic [63:0]         pat_hi_ff;
   logic [15:0]         care_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [LEN_W-1:0]    eff_len;
   cell_cfg_type        cell_cfg;

   logic [OFFSET_W-1:0] seen_ff,  seen_in;
   logic                done_ff,  done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   logic [MAX_PATTERN-1:0]      cell_ok;
   logic [7:0]                  win [MAX_PATTERN];
   logic [7:0]                  chain_in [MAX_PATTERN];
   logic                        accept;
   logic                        shift_en;
   logic [OFFSET_W-1:0]         seen_next;
   logic [OFFSET_W-1:0]         len_wide;
   logic                        hit;
   logic                        emit;

   always_comb begin
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_ff > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = len_ff;
      end
   end

   assign cell_cfg.pat  = {pat_hi_ff, pat_lo_ff};
   assign cell_cfg.care = care_ff;
   assign cell_cfg.len  = eff_len;

   assign accept   = req_tvalid && req_tready;
   assign shift_en = accept && !done_ff;

   genvar k;
   generate
      for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
         if (k == 0) begin : g_head
            assign chain_in[k] = req_tdata;
         end else begin : g_body
            assign chain_in[k] = win[k-1];
         end
         mbps_cell #(
            .IDX (k)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .shift_in (chain_in[k]),
            .cfg      (cell_cfg),
            .byte_out (win[k]),
            .ok       (cell_ok[k])
         );
      end
   endgenerate

   // saturating count including the byte now arriving
   assign seen_next = (seen_ff == '1) ? seen_ff : seen_ff + OFFSET_W'(1);
   assign len_wide  = OFFSET_W'(eff_len);
   assign hit       = (seen_next >= len_wide) && (&cell_ok);
   assign emit      = shift_en && (hit || req_tlast);

   always_comb begin
      seen_in = seen_ff;
      done_in = done_ff;
      if (accept) begin
         if (req_tlast) begin
            seen_in = '0;
            done_in = 1'b0;
         end else if (!done_ff) begin
            seen_in = seen_next;
            done_in = hit;
         end
      end
   end

   // output register: loads a new word as the old one leaves
   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = hit;
         rsp_offset_in = hit ? (seen_next - len_wide) : '0;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff    <= '0;
         pat_hi_ff    <= '0;
         care_ff      <= '0;
         len_ff       <= LEN_W'(1);
         seen_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_PAT_LO: pat_lo_ff <= csr_data;
               CSR_PAT_HI: pat_hi_ff <= csr_data;
               CSR_CARE:   care_ff   <= csr_data[15:0];
               CSR_LEN:    len_ff    <= csr_data[LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_offset_ff;

endmodule

/* rtl/mbps_cell.sv */
// One window cell: holds one byte of the sliding window and checks it against its pattern byte
module mbps_cell #(
   parameter int IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  logic [7:0]           shift_in,
   input  mbps_pkg::cell_cfg_type cfg,
   output logic [7:0]           byte_out,
   output logic                 ok
);
   import mbps_pkg::*;

   localparam logic [6:0] POS = 7'(IDX);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic [6:0] len_ext;
   logic [6:0] pat_pos;
   logic       care;

   // cell IDX (0 is newest) lines up with pattern byte len-1-IDX
   assign len_ext = {2'b00, cfg.len};
   assign pat_pos = len_ext - 7'd1 - POS;
   assign care    = (POS < len_ext) && (pat_pos < 7'(PAT_BYTES))
                    && cfg.care[pat_pos[3:0]];

   // compare the byte this cell is about to take in
   assign ok      = !care || (shift_in == cfg.pat[pat_pos[3:0]]);
   assign byte_in = shift_en ? shift_in : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

/* rtl/mbps_checker.sv */
// Port-level checks of the masked byte pattern search unit, bound to the top level
`include "masked_byte_pattern_search_unit_defines.svh"

module mbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result word holds
   `MBPS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // not-found words carry a zero offset
   `MBPS_ASSERT(a_notfound_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata == 32'd0)

   // a new result word only follows an accepted input word
   `MBPS_ASSERT(a_rsp_cause, clock, reset, $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))

   // with no word pending the input side is open
   `MBPS_ASSERT(a_ready_idle, clock, reset, !rsp_tvalid |-> req_tready)

   // reset leaves no result pending
   `MBPS_ASSERT_ALL(a_reset_clear, clock, reset |=> !rsp_tvalid)

endmodule

bind masked_byte_pattern_search_unit mbps_checker u_mbps_checker (.*);
